FILE: src/rci_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the RGBA convolution block.
// No dependencies; imported by every module of the block.
package rci_pkg;

    localparam int FIELD_W   = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [1:0] FUNC_LOAD  = 2'd0;
    localparam logic [1:0] FUNC_PIXEL = 2'd1;

    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_SIZE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIVISOR      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LEVEL    = 3'd4;

    typedef struct packed {
        logic clear;
        logic mac;
        logic div_start;
    } lane_ctrl_t;

endpackage

FILE: src/rci_lane.sv
`timescale 1ns / 1ps
// One colour lane: multiply-accumulate over the kernel taps, then
// restoring division and clamp. Depends on rci_pkg.
module rci_lane #(
    parameter int ACC_W = 39
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  rci_pkg::lane_ctrl_t              ctrl,
    input  logic [rci_pkg::FIELD_W-1:0]      sample,
    input  logic signed [rci_pkg::FIELD_W-1:0] coef,
    input  logic [rci_pkg::FIELD_W-1:0]      dvsr,
    input  logic [rci_pkg::FIELD_W-1:0]      max_level,
    output logic [rci_pkg::FIELD_W-1:0]      result,
    output logic                             done
);
    import rci_pkg::*;

    localparam int N     = ACC_W - 1;
    localparam int CNT_W = $clog2(N + 1);
    localparam int PR_W  = 2 * FIELD_W + 1;

    logic signed [PR_W-1:0]  prod_reg, prod_next;
    logic                    pvld_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic [N-1:0]            quo_reg, quo_next;
    logic [FIELD_W-1:0]      rem_reg, rem_next;
    logic [FIELD_W:0]        rem_sh;
    logic                    ge;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    busy_reg, pos_reg, done_reg;

    assign prod_next = $signed({1'b0, sample}) * coef;
    assign rem_sh    = {rem_reg, quo_reg[N-1]};
    assign ge        = rem_sh >= {1'b0, dvsr};
    assign rem_next  = ge ? FIELD_W'(rem_sh - {1'b0, dvsr}) : rem_sh[FIELD_W-1:0];
    assign quo_next  = {quo_reg[N-2:0], ge};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pvld_reg <= 1'b0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            pos_reg  <= 1'b0;
            acc_reg  <= '0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (ctrl.clear) begin
                pvld_reg <= 1'b0;
                acc_reg  <= '0;
            end else begin
                pvld_reg <= ctrl.mac;
                if (pvld_reg) begin
                    acc_reg <= acc_reg + ACC_W'(prod_reg);
                end
            end
            if (ctrl.div_start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(N);
                pos_reg  <= !acc_reg[ACC_W-1] && (acc_reg != '0);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.mac) begin
            prod_reg <= prod_next;
        end
        if (ctrl.div_start) begin
            quo_reg <= acc_reg[N-1:0];
            rem_reg <= '0;
        end else if (busy_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    always_comb begin
        if (!pos_reg) begin
            result = '0;
        end else if (quo_reg > N'(max_level)) begin
            result = max_level;
        end else begin
            result = quo_reg[FIELD_W-1:0];
        end
    end

    assign done = done_reg;

endmodule

FILE: src/rci_merge.sv
`timescale 1ns / 1ps
// Output stage: gathers the lane results, alpha and frame end into one
// held result transfer. Depends on rci_pkg.
module rci_merge (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        push,
    input  logic [rci_pkg::FIELD_W-1:0] red,
    input  logic [rci_pkg::FIELD_W-1:0] green,
    input  logic [rci_pkg::FIELD_W-1:0] blue,
    input  logic [rci_pkg::FIELD_W-1:0] alpha,
    input  logic                        fend,
    output logic                        can_push,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [4*rci_pkg::FIELD_W-1:0] m_tdata,
    output logic                        m_tlast
);
    import rci_pkg::*;

    logic                  valid_reg;
    logic [4*FIELD_W-1:0]  data_reg;
    logic                  last_reg;

    assign can_push = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (push) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            data_reg <= {alpha, blue, green, red};
            last_reg <= fend;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

endmodule

FILE: src/rgb_convolution_2d_int_top.sv
`timescale 1ns / 1ps
// RGBA K x K convolution, top level. A coefficient load, or a pixel/drain
// that produces no output, leaves the input ready for the next transfer. An
// item that produces an output holds the input off until its result is pushed:
// after the accept come the scan of the K*K taps, the pipeline flush, the
// bit-serial divider and the push, which waits while the output is stalled.
// aresetn (synchronous) clears counters, control and config registers to defaults.
module rgb_convolution_2d_int_top #(
    parameter int MAX_WIDTH   = 2048,
    parameter int MAX_KERNEL  = 7,
    parameter int SAMPLE_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // coef_index[5:0], coef_value[21:6], red[37:22], green[53:38],
    // blue[69:54], alpha[85:70], zero[87:86]
    input  logic [87:0] s_tdata,
    // func[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // out_red[15:0], out_green[31:16], out_blue[47:32], out_alpha[63:48]
    output logic [63:0] m_tdata,
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import rci_pkg::*;

    localparam int LINE_ROWS  = 2 * MAX_KERNEL;
    localparam int COEF_DEPTH = MAX_KERNEL * MAX_KERNEL;
    localparam int HMAX       = MAX_KERNEL / 2;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int W_W        = $clog2(MAX_WIDTH + 1);
    localparam int CC_W       = COL_W + 1;
    localparam int SLOT_W     = $clog2(LINE_ROWS);
    localparam int ADDR_W     = $clog2(LINE_ROWS * MAX_WIDTH);
    localparam int CI_W       = $clog2(COEF_DEPTH);
    localparam int H_W        = $clog2(HMAX + 1);
    localparam int K_W        = H_W + 1;
    localparam int PCNT_W     = 12 + W_W;
    localparam int ACC_W      = 2 * FIELD_W + 1 + $clog2(COEF_DEPTH);
    localparam logic [FIELD_W-1:0] SMASK = FIELD_W'((1 << SAMPLE_BITS) - 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_FLUSH = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_PUSH  = 3'd4;

    // configuration
    logic [2:0]         ksize_reg;
    logic [11:0]        fwidth_reg, fheight_reg;
    logic [15:0]        divisor_reg, maxlvl_reg;

    // frame counters
    logic [COL_W-1:0]   in_col_reg, in_col_next, out_col_reg, out_col_next;
    logic [11:0]        in_row_reg, in_row_next, out_row_reg, out_row_next;
    logic [SLOT_W-1:0]  in_slot_reg, in_slot_next, out_slot_reg, out_slot_next;
    logic [PCNT_W-1:0]  pcnt_reg, pcnt_next;

    // scan
    logic [2:0]         state_reg, state_next;
    logic [K_W-1:0]     a_reg, a_next, b_reg, b_next;
    logic [12:0]        rrow_reg, rrow_next;
    logic [CC_W-1:0]    ccol_reg, ccol_next;
    logic [COL_W-1:0]   cbase_reg, cbase_next;
    logic [SLOT_W-1:0]  rslot_reg, rslot_next;
    logic [CI_W-1:0]    cidx_reg, cidx_next;
    logic [1:0]         flush_reg, flush_next;
    logic               vld1_reg, ctr1_reg;
    logic [FIELD_W-1:0] alpha_reg;
    logic               fend_reg, fend_next;

    // memories
    logic [4*FIELD_W-1:0] line_mem [LINE_ROWS*MAX_WIDTH];
    logic [FIELD_W-1:0]   coef_mem [COEF_DEPTH];
    logic [4*FIELD_W-1:0] pix_rd_reg;
    logic [FIELD_W-1:0]   coef_rd_reg;

    // derived geometry
    logic [W_W-1:0]     eff_w;
    logic [11:0]        eff_h;
    logic [H_W-1:0]     hk;
    logic [K_W-1:0]     kk;
    logic [2*K_W-1:0]   elems;
    logic [PCNT_W-1:0]  lag;
    logic [15:0]        dv;

    logic               accept, cfg_we, geo_write;
    logic [1:0]         func;
    logic [5:0]         in_cidx;
    logic               is_pixel, emit, fend_now, tap_ok, center;
    logic [SLOT_W:0]    slot_tmp;
    logic [ADDR_W-1:0]  waddr, raddr;
    logic [4*FIELD_W-1:0] px;
    logic [12:0]        rsub;
    logic [CC_W-1:0]    csub;

    lane_ctrl_t           lane_ctrl;
    logic [FIELD_W-1:0]   lane_res [3];
    logic [2:0]           lane_done;
    logic                 can_push, push;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign geo_write = cfg_we && (cfg_index == REG_KERNEL_SIZE ||
                       cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ksize_reg   <= 3'd3;
            fwidth_reg  <= 12'(2048);
            fheight_reg <= 12'(2048);
            divisor_reg <= 16'd1;
            maxlvl_reg  <= 16'd255;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_KERNEL_SIZE:  ksize_reg   <= cfg_data[2:0];
                REG_FRAME_WIDTH:  fwidth_reg  <= cfg_data[11:0];
                REG_FRAME_HEIGHT: fheight_reg <= cfg_data[11:0];
                REG_DIVISOR:      divisor_reg <= cfg_data;
                REG_MAX_LEVEL:    maxlvl_reg  <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_comb begin
        if (fwidth_reg == '0) begin
            eff_w = W_W'(1);
        end else if (32'(fwidth_reg) > 32'(MAX_WIDTH)) begin
            eff_w = W_W'(MAX_WIDTH);
        end else begin
            eff_w = W_W'(fwidth_reg);
        end
        eff_h = (fheight_reg == '0) ? 12'd1 : fheight_reg;
        hk    = (32'(ksize_reg >> 1) > 32'(HMAX)) ? H_W'(HMAX) : H_W'(ksize_reg >> 1);
        kk    = {hk, 1'b1};
        elems = (2*K_W)'(kk) * (2*K_W)'(kk);
        lag   = PCNT_W'(hk) * PCNT_W'(eff_w) + PCNT_W'(hk);
        dv    = (divisor_reg == '0) ? 16'd1 : divisor_reg;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign func     = s_tuser;
    assign in_cidx  = s_tdata[5:0];
    assign px       = {s_tdata[85:70] & SMASK, s_tdata[69:54] & SMASK,
                       s_tdata[53:38] & SMASK, s_tdata[37:22] & SMASK};

    assign is_pixel = (func == FUNC_PIXEL) && (in_row_reg < eff_h);
    assign emit     = is_pixel ? (pcnt_reg >= lag)
                    : ((func != FUNC_LOAD) && (in_row_reg >= eff_h) && (out_row_reg < eff_h));
    assign fend_now = (out_row_reg == eff_h - 12'd1) && (W_W'(out_col_reg) == eff_w - W_W'(1));

    assign slot_tmp = (SLOT_W+1)'(out_slot_reg) + (SLOT_W+1)'(LINE_ROWS) - (SLOT_W+1)'(hk);

    // tap geometry
    assign rsub   = rrow_reg - 13'(hk);
    assign csub   = ccol_reg - CC_W'(hk);
    assign tap_ok = (rrow_reg >= 13'(hk)) && (rsub < 13'(eff_h)) &&
                    (ccol_reg >= CC_W'(hk)) && (csub < CC_W'(eff_w));
    assign center = (a_reg == K_W'(hk)) && (b_reg == K_W'(hk));
    assign raddr  = ADDR_W'(rslot_reg) * ADDR_W'(MAX_WIDTH) + ADDR_W'(csub[COL_W-1:0]);
    assign waddr  = ADDR_W'(in_slot_reg) * ADDR_W'(MAX_WIDTH) + ADDR_W'(in_col_reg);

    always_comb begin
        in_col_next   = in_col_reg;
        in_row_next   = in_row_reg;
        in_slot_next  = in_slot_reg;
        pcnt_next     = pcnt_reg;
        out_col_next  = out_col_reg;
        out_row_next  = out_row_reg;
        out_slot_next = out_slot_reg;
        state_next    = state_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        rrow_next     = rrow_reg;
        ccol_next     = ccol_reg;
        cbase_next    = cbase_reg;
        rslot_next    = rslot_reg;
        cidx_next     = cidx_reg;
        flush_next    = flush_reg;
        fend_next     = fend_reg;
        push          = 1'b0;
        lane_ctrl     = '0;

        case (state_reg)
            ST_IDLE: begin
                if (accept && is_pixel) begin
                    pcnt_next = pcnt_reg + 1'b1;
                    if (W_W'(in_col_reg) + W_W'(1) >= eff_w) begin
                        in_col_next = '0;
                        in_row_next = in_row_reg + 12'd1;
                        in_slot_next = (32'(in_slot_reg) == LINE_ROWS - 1) ? '0
                                     : in_slot_reg + 1'b1;
                    end else begin
                        in_col_next = in_col_reg + 1'b1;
                    end
                end
                if (accept && emit) begin
                    lane_ctrl.clear = 1'b1;
                    fend_next  = fend_now;
                    a_next     = '0;
                    b_next     = '0;
                    rrow_next  = 13'(out_row_reg);
                    ccol_next  = CC_W'(out_col_reg);
                    cbase_next = out_col_reg;
                    rslot_next = (slot_tmp >= (SLOT_W+1)'(LINE_ROWS))
                               ? SLOT_W'(slot_tmp - (SLOT_W+1)'(LINE_ROWS))
                               : SLOT_W'(slot_tmp);
                    cidx_next  = CI_W'(elems - 1'b1);
                    state_next = ST_SCAN;
                    if (fend_now) begin
                        in_col_next   = '0;
                        in_row_next   = '0;
                        in_slot_next  = '0;
                        pcnt_next     = '0;
                        out_col_next  = '0;
                        out_row_next  = '0;
                        out_slot_next = '0;
                    end else if (W_W'(out_col_reg) + W_W'(1) >= eff_w) begin
                        out_col_next  = '0;
                        out_row_next  = out_row_reg + 12'd1;
                        out_slot_next = (32'(out_slot_reg) == LINE_ROWS - 1) ? '0
                                      : out_slot_reg + 1'b1;
                    end else begin
                        out_col_next = out_col_reg + 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                cidx_next = cidx_reg - 1'b1;
                if (b_reg == kk - 1'b1) begin
                    b_next    = '0;
                    ccol_next = CC_W'(cbase_reg);
                    a_next    = a_reg + 1'b1;
                    rrow_next = rrow_reg + 13'd1;
                    rslot_next = (32'(rslot_reg) == LINE_ROWS - 1) ? '0
                               : rslot_reg + 1'b1;
                    if (a_reg == kk - 1'b1) begin
                        flush_next = '0;
                        state_next = ST_FLUSH;
                    end
                end else begin
                    b_next    = b_reg + 1'b1;
                    ccol_next = ccol_reg + 1'b1;
                end
            end
            ST_FLUSH: begin
                flush_next = flush_reg + 1'b1;
                if (flush_reg == 2'd3) begin
                    lane_ctrl.div_start = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (lane_done[0]) begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (can_push) begin
                    push       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        lane_ctrl.mac = vld1_reg;

        if (geo_write) begin
            in_col_next   = '0;
            in_row_next   = '0;
            in_slot_next  = '0;
            pcnt_next     = '0;
            out_col_next  = '0;
            out_row_next  = '0;
            out_slot_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            in_slot_reg  <= '0;
            pcnt_reg     <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            out_slot_reg <= '0;
            vld1_reg     <= 1'b0;
            ctr1_reg     <= 1'b0;
            flush_reg    <= '0;
        end else begin
            state_reg    <= state_next;
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            in_slot_reg  <= in_slot_next;
            pcnt_reg     <= pcnt_next;
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
            out_slot_reg <= out_slot_next;
            vld1_reg     <= (state_reg == ST_SCAN) && tap_ok;
            ctr1_reg     <= (state_reg == ST_SCAN) && tap_ok && center;
            flush_reg    <= flush_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg     <= a_next;
        b_reg     <= b_next;
        rrow_reg  <= rrow_next;
        ccol_reg  <= ccol_next;
        cbase_reg <= cbase_next;
        rslot_reg <= rslot_next;
        cidx_reg  <= cidx_next;
        fend_reg  <= fend_next;
        if (ctr1_reg) begin
            alpha_reg <= pix_rd_reg[4*FIELD_W-1:3*FIELD_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && is_pixel) begin
            line_mem[waddr] <= px;
        end
        pix_rd_reg <= line_mem[raddr];
    end

    always_ff @(posedge aclk) begin
        if (accept && func == FUNC_LOAD && 32'(in_cidx) < COEF_DEPTH) begin
            coef_mem[CI_W'(in_cidx)] <= s_tdata[21:6];
        end
        coef_rd_reg <= coef_mem[cidx_reg];
    end

    for (genvar ch = 0; ch < 3; ch++) begin : g_lane
        rci_lane #(
            .ACC_W (ACC_W)
        ) u_lane (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (lane_ctrl),
            .sample    (pix_rd_reg[ch*FIELD_W +: FIELD_W]),
            .coef      ($signed(coef_rd_reg)),
            .dvsr      (dv),
            .max_level (maxlvl_reg),
            .result    (lane_res[ch]),
            .done      (lane_done[ch])
        );
    end

    rci_merge u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .red      (lane_res[0]),
        .green    (lane_res[1]),
        .blue     (lane_res[2]),
        .alpha    (alpha_reg),
        .fend     (fend_reg),
        .can_push (can_push),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

FILE: src/rci_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the RGBA convolution top level, bound to it below.
// Depends only on the top level's ports.
module rci_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [87:0] s_tdata,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic        m_tlast,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic [2:0]  cfg_index,
    input logic [15:0] cfg_data
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // drop any pending result on reset
    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // come out of reset ready for input
    a_reset_in: assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("input not ready after reset");

    // a coefficient load never blocks the next transfer
    a_load_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == 2'd0 |=> s_tready)
        else $error("input stalled after coefficient load");

endmodule

bind rgb_convolution_2d_int_top rci_checker u_rci_checker (.*);
